// File: src/smspdu_pkg.sv
// shared types, codes and decode helpers for the sms-deliver pdu hex parser
package smspdu_pkg;

  // walk through the pdu fields
  typedef enum logic [3:0] {
    PH_SMSC_LEN  = 4'd0,
    PH_SMSC_TYPE = 4'd1,
    PH_SMSC_DIG  = 4'd2,
    PH_FIRST     = 4'd3,
    PH_OA_LEN    = 4'd4,
    PH_OA_TYPE   = 4'd5,
    PH_OA_DIG    = 4'd6,
    PH_PID       = 4'd7,
    PH_DCS       = 4'd8,
    PH_TS        = 4'd9,
    PH_UDL       = 4'd10,
    PH_UD        = 4'd11,
    PH_IDLE      = 4'd12
  } phase_t;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_SMSC   = 3'd1;
  localparam logic [2:0] KIND_SENDER = 3'd2;
  localparam logic [2:0] KIND_PID    = 3'd3;
  localparam logic [2:0] KIND_DCS    = 3'd4;
  localparam logic [2:0] KIND_TSTAMP = 3'd5;
  localparam logic [2:0] KIND_UDL    = 3'd6;
  localparam logic [2:0] KIND_DATA   = 3'd7;

  localparam logic [7:0] ASCII_0 = 8'h30;
  localparam logic [7:0] ASCII_9 = 8'h39;
  localparam logic [7:0] ASCII_A = 8'h41;
  localparam logic [7:0] ASCII_F = 8'h46;

  typedef struct packed {
    logic [2:0] field_kind;
    logic [7:0] byte_value;
    logic [7:0] first_digit;
    logic [7:0] second_digit;
    logic       second_valid;
    logic       message_done;
  } result_t;

  // digits map to 0-9, anything else follows the letter rule, kept to 8 bits
  function automatic logic [7:0] nib_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= ASCII_0 && c <= ASCII_9) begin
      v = c - ASCII_0;
    end else begin
      v = c - ASCII_A + 8'd10;
    end
    return v;
  endfunction

endpackage

// File: src/smspdu_parse_core.sv
// input register, pdu field walker and result formation
module smspdu_parse_core #(
  parameter int TIMESTAMP_DIGITS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [7:0]             in_hex_char,
  input  logic                   in_start_flag,
  output logic                   in_ready,
  output logic                   res_valid,
  output smspdu_pkg::result_t    res,
  input  logic                   res_ready
);

  localparam int TsCharsInt = (TIMESTAMP_DIGITS + 1) & ~1;
  localparam logic [8:0] TS_CHARS = 9'(TsCharsInt);

  logic                   item_v_r;
  logic [7:0]             char_r;
  logic                   start_r;

  smspdu_pkg::phase_t     phase_r, phase_nxt;
  logic [7:0]             held_r, held_nxt;
  logic                   half_r, half_nxt;
  logic [8:0]             rem_r, rem_nxt;
  logic [3:0]             hi_r, hi_nxt;

  logic                   take;
  smspdu_pkg::phase_t     ph;
  logic [8:0]             rem_w;
  logic [7:0]             nib;
  logic [7:0]             b;
  logic                   last;

  assign take     = item_v_r & res_ready;
  assign in_ready = ~item_v_r | res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_r  <= in_hex_char;
      start_r <= in_start_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= smspdu_pkg::PH_SMSC_LEN;
      held_r  <= '0;
      half_r  <= 1'b0;
      rem_r   <= '0;
      hi_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      half_r  <= half_nxt;
      rem_r   <= rem_nxt;
      hi_r    <= hi_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    half_nxt  = half_r;
    rem_nxt   = rem_r;
    hi_nxt    = hi_r;
    res_valid = 1'b0;
    res       = '0;
    nib       = smspdu_pkg::nib_value(char_r);
    b         = {hi_r, 4'b0000} | nib;
    last      = 1'b0;
    ph        = start_r ? smspdu_pkg::PH_SMSC_LEN : phase_r;
    rem_w     = start_r ? 9'd0 : rem_r;

    if (take) begin
      phase_nxt = ph;
      rem_nxt   = rem_w;
      half_nxt  = start_r ? 1'b0 : half_r;
      if (ph != smspdu_pkg::PH_IDLE) begin
        if (start_r || !half_r) begin
          // first character of a pair
          held_nxt = char_r;
          hi_nxt   = nib[3:0];
          half_nxt = 1'b1;
        end else begin
          half_nxt       = 1'b0;
          res_valid      = 1'b1;
          res.byte_value = b;
          res.field_kind = smspdu_pkg::KIND_HEADER;
          unique case (ph) inside
            smspdu_pkg::PH_SMSC_LEN: begin
              if (b == 8'd0) begin
                phase_nxt = smspdu_pkg::PH_FIRST;
              end else begin
                rem_nxt   = {b - 8'd1, 1'b0};
                phase_nxt = smspdu_pkg::PH_SMSC_TYPE;
              end
            end
            smspdu_pkg::PH_SMSC_TYPE: begin
              phase_nxt = (rem_w != 9'd0) ? smspdu_pkg::PH_SMSC_DIG : smspdu_pkg::PH_FIRST;
            end
            smspdu_pkg::PH_FIRST: begin
              phase_nxt = smspdu_pkg::PH_OA_LEN;
            end
            smspdu_pkg::PH_OA_LEN: begin
              rem_nxt   = {1'b0, b} + {8'd0, b[0]};
              phase_nxt = smspdu_pkg::PH_OA_TYPE;
            end
            smspdu_pkg::PH_OA_TYPE: begin
              phase_nxt = (rem_w != 9'd0) ? smspdu_pkg::PH_OA_DIG : smspdu_pkg::PH_PID;
            end
            smspdu_pkg::PH_PID: begin
              res.field_kind = smspdu_pkg::KIND_PID;
              phase_nxt      = smspdu_pkg::PH_DCS;
            end
            smspdu_pkg::PH_DCS: begin
              res.field_kind = smspdu_pkg::KIND_DCS;
              rem_nxt        = TS_CHARS;
              phase_nxt      = (TS_CHARS != 9'd0) ? smspdu_pkg::PH_TS : smspdu_pkg::PH_UDL;
            end
            smspdu_pkg::PH_UDL: begin
              res.field_kind   = smspdu_pkg::KIND_UDL;
              res.message_done = (b == 8'd0);
              rem_nxt          = {b, 1'b0};
              phase_nxt        = (b != 8'd0) ? smspdu_pkg::PH_UD : smspdu_pkg::PH_IDLE;
            end
            smspdu_pkg::PH_UD: begin
              last             = (rem_w <= 9'd2);
              rem_nxt          = last ? 9'd0 : rem_w - 9'd2;
              res.field_kind   = smspdu_pkg::KIND_DATA;
              res.message_done = last;
              if (last) begin
                phase_nxt = smspdu_pkg::PH_IDLE;
              end
            end
            smspdu_pkg::PH_SMSC_DIG,
            smspdu_pkg::PH_OA_DIG,
            smspdu_pkg::PH_TS: begin
              // semi-octet fields: swap the pair, drop a trailing filler
              last              = (rem_w <= 9'd2);
              rem_nxt           = last ? 9'd0 : rem_w - 9'd2;
              res.first_digit   = char_r;
              res.second_digit  = held_r;
              res.second_valid  = ~(last && held_r == smspdu_pkg::ASCII_F);
              if (ph == smspdu_pkg::PH_SMSC_DIG) begin
                res.field_kind = smspdu_pkg::KIND_SMSC;
                if (last) phase_nxt = smspdu_pkg::PH_FIRST;
              end else if (ph == smspdu_pkg::PH_OA_DIG) begin
                res.field_kind = smspdu_pkg::KIND_SENDER;
                if (last) phase_nxt = smspdu_pkg::PH_PID;
              end else begin
                res.field_kind = smspdu_pkg::KIND_TSTAMP;
                if (last) phase_nxt = smspdu_pkg::PH_UDL;
              end
            end
            default: begin
              res_valid = 1'b0;
            end
          endcase
        end
      end
    end
  end

endmodule

// File: src/smspdu_out_reg.sv
// result register with valid/ready toward the receiver
module smspdu_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  smspdu_pkg::result_t res,
  output logic                res_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output smspdu_pkg::result_t out_data
);

  logic                out_v_r;
  smspdu_pkg::result_t data_r;

  assign res_ready = ~out_v_r | out_ready;
  assign out_valid = out_v_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_ready) begin
      out_v_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

endmodule

// File: src/sms_pdu_hex_deliver_parser.sv
// top level of the sms-deliver pdu hex parser
//
// input channel: one ascii character of the hex pdu text per transaction
// (in_hex_char), in_start_flag high on the first character of a new pdu.
// output channel: one transaction per completed byte with the field kind,
// the byte, the swapped digit characters for semi-octet fields and the
// end-of-message flag. the first character of a pair and characters after
// the end of the message give no output transaction.
// path: an accepted character sits in the input register, then the field
// walker loads the result register, which drives out_valid.
// throughput: one character per cycle while the receiver does not stall,
// set by the combinational walker between the input and result registers.
// reset (rst_n low, synchronous) empties both registers and returns the
// walker to waiting for the smsc length.
// while the receiver stalls the result is held; one more character waits in
// the input register, then in_ready drops until out_ready returns.
module sms_pdu_hex_deliver_parser #(
  parameter int TIMESTAMP_DIGITS = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_hex_char,
  input  logic       in_start_flag,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_field_kind,
  output logic [7:0] out_byte_value,
  output logic [7:0] out_first_digit,
  output logic [7:0] out_second_digit,
  output logic       out_second_valid,
  output logic       out_message_done
);

  logic                res_valid;
  logic                res_ready;
  smspdu_pkg::result_t res;
  smspdu_pkg::result_t out_data;

  smspdu_parse_core #(
    .TIMESTAMP_DIGITS(TIMESTAMP_DIGITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_hex_char  (in_hex_char),
    .in_start_flag(in_start_flag),
    .in_ready     (in_ready),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready)
  );

  smspdu_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign out_field_kind   = out_data.field_kind;
  assign out_byte_value   = out_data.byte_value;
  assign out_first_digit  = out_data.first_digit;
  assign out_second_digit = out_data.second_digit;
  assign out_second_valid = out_data.second_valid;
  assign out_message_done = out_data.message_done;

endmodule

// File: src/smspdu_checker.sv
// port-level checks for the sms-deliver pdu hex parser, bound to the top level
module smspdu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_field_kind,
  input logic [7:0] out_byte_value,
  input logic [7:0] out_first_digit,
  input logic [7:0] out_second_digit,
  input logic       out_second_valid,
  input logic       out_message_done
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_value)
      && $stable(out_field_kind) && $stable(out_message_done))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // only semi-octet fields carry digit characters
  a_digits_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_kind != smspdu_pkg::KIND_SMSC
      && out_field_kind != smspdu_pkg::KIND_SENDER
      && out_field_kind != smspdu_pkg::KIND_TSTAMP
    |-> out_first_digit == 8'd0 && out_second_digit == 8'd0 && !out_second_valid)
    else $error("digit characters on a non-digit field");

  // end of message only on user data length or user data
  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_done
    |-> out_field_kind == smspdu_pkg::KIND_UDL || out_field_kind == smspdu_pkg::KIND_DATA)
    else $error("message end on wrong field");

  // a data length ends the message exactly when it is zero
  a_udl_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_kind == smspdu_pkg::KIND_UDL
    |-> out_message_done == (out_byte_value == 8'd0))
    else $error("zero data length mismatch");

endmodule

bind sms_pdu_hex_deliver_parser smspdu_checker u_smspdu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_field_kind  (out_field_kind),
  .out_byte_value  (out_byte_value),
  .out_first_digit (out_first_digit),
  .out_second_digit(out_second_digit),
  .out_second_valid(out_second_valid),
  .out_message_done(out_message_done)
);
